>>> hw/rtl/lsm_pkg.sv
// lsm_pkg: shared types, constants and helpers of the line substring matcher
// depends on nothing; used by all lsm modules

package lsm_pkg;

   localparam int PATTERN_MAX_DEF = 128;
   localparam int LINE_KEEP_DEF   = 510;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [7:0] NEWLINE_CHAR = 8'd10;
   localparam logic [7:0] ZERO_CHAR    = 8'd0;

   // input action codes
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_TEXT = 2'd1;
   localparam logic [1:0] ACT_END  = 2'd2;

   // configuration register indexes
   localparam logic CSR_CASE_FOLD   = 1'b0;
   localparam logic CSR_PATTERN_LEN = 1'b1;

   typedef enum logic [1:0] {
      KIND_PATTERN,
      KIND_TEXT,
      KIND_NEWLINE,
      KIND_END
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  pattern_index;
      logic [7:0]  data_byte;
   } entry_type;

   typedef struct packed {
      logic        case_fold;
      logic [6:0]  pattern_length;
   } cfg_type;

   typedef struct packed {
      logic [15:0] line_number;
      logic        line_matched;
      logic [8:0]  first_column;
      logic [8:0]  occurrence_count;
      logic [15:0] matching_lines_total;
      logic        end_of_text;
   } result_type;

   // ascii upper case onto lower case when folding is on
   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
      logic [7:0] r;
      r = c;
      if (en && c >= 8'd65 && c <= 8'd90) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/lsm_channels.sv
// lsm_channels: valid/ready channel interfaces of the line substring matcher
// depends on nothing beyond plain logic types

interface lsm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [6:0] pattern_index;
   logic [7:0] data_byte;
   modport source (output valid, action, pattern_index, data_byte, input ready);
   modport sink (input valid, action, pattern_index, data_byte, output ready);
endinterface

interface lsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] line_number;
   logic        line_matched;
   logic [8:0]  first_column;
   logic [8:0]  occurrence_count;
   logic [15:0] matching_lines_total;
   logic        end_of_text;
   modport source (output valid, line_number, line_matched, first_column,
                   occurrence_count, matching_lines_total, end_of_text, input ready);
   modport sink (input valid, line_number, line_matched, first_column,
                 occurrence_count, matching_lines_total, end_of_text, output ready);
endinterface

interface lsm_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [6:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/lsm_queue.sv
// lsm_queue: small fifo of classified beats between front and back
// depends on lsm_pkg (entry_type)

module lsm_queue #(
   parameter int DEPTH = lsm_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lsm_pkg::entry_type  push_entry,
   output logic                has_space,
   input  logic                pop,
   output logic                not_empty,
   output lsm_pkg::entry_type  head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lsm_pkg::entry_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign has_space = count_ff != CW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/lsm_front.sv
// lsm_front: accepts request beats and classifies them for the back end
// depends on lsm_pkg and lsm_req_if

module lsm_front (
   lsm_req_if.sink             req_if,
   input  logic                queue_space,
   output logic                push,
   output lsm_pkg::entry_type  push_entry
);

   logic known;

   assign req_if.ready = queue_space;

   always_comb begin
      known                    = 1'b1;
      push_entry.pattern_index = req_if.pattern_index;
      push_entry.data_byte     = req_if.data_byte;
      push_entry.kind          = lsm_pkg::KIND_TEXT;
      case (req_if.action)
         lsm_pkg::ACT_LOAD: begin
            push_entry.kind = lsm_pkg::KIND_PATTERN;
         end
         lsm_pkg::ACT_TEXT: begin
            if (req_if.data_byte == lsm_pkg::NEWLINE_CHAR) begin
               push_entry.kind = lsm_pkg::KIND_NEWLINE;
            end else begin
               push_entry.kind = lsm_pkg::KIND_TEXT;
            end
         end
         lsm_pkg::ACT_END: begin
            push_entry.kind = lsm_pkg::KIND_END;
         end
         default: begin
            // undefined action is swallowed
            known = 1'b0;
         end
      endcase
   end

   assign push = req_if.valid && queue_space && known;

endmodule

>>> hw/rtl/lsm_back.sv
// lsm_back: pattern store, text window compare, line bookkeeping, result register
// depends on lsm_pkg and lsm_rsp_if

module lsm_back #(
   parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF,
   parameter int LINE_KEEP   = lsm_pkg::LINE_KEEP_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  lsm_pkg::cfg_type    cfg,
   input  logic                head_valid,
   input  lsm_pkg::entry_type  head,
   output logic                pop,
   lsm_rsp_if.source           rsp_if
);

   localparam int WD = PATTERN_MAX - 1;
   localparam int LW = $clog2(PATTERN_MAX);
   localparam int KW = $clog2(LINE_KEEP + 1);
   localparam int CW = (KW > LW) ? KW + 1 : LW + 1;

   logic [7:0]  pattern_ff [PATTERN_MAX];
   logic [7:0]  win_ff [WD];
   logic [7:0]  win_in [WD];

   logic [KW-1:0] kept_ff, kept_in;
   logic [KW-1:0] next_start_ff, next_start_in;
   logic [KW-1:0] first_ff, first_in;
   logic [8:0]    hits_ff, hits_in;
   logic          zero_ff, zero_in;
   logic [15:0]   line_ff, line_in;
   logic [15:0]   total_ff, total_in;

   logic                 out_valid_ff, out_valid_in;
   lsm_pkg::result_type  out_ff, out_in;

   logic          out_free, makes_result, closing, is_end, text_take, win_shift;
   logic [7:0]    len8;
   logic [LW-1:0] len;
   logic [LW-1:0] pad;
   logic [8*WD-1:0] win_vec, win_align;
   logic [KW-1:0] kept_next, start;
   logic          hit, enough, matched;
   logic [15:0]   total_next;
   logic [8:0]    idx9;
   logic [8:0]    first_out;

   // active pattern length, clamped into the window
   always_comb begin
      len8 = {1'b0, cfg.pattern_length};
      if (len8 == 8'd0) begin
         len8 = 8'd1;
      end
      if (len8 > 8'(WD)) begin
         len8 = 8'(WD);
      end
      len = LW'(len8);
   end

   assign pad = LW'(WD) - len;

   // window after the new byte; a byte shifter lines the newest len bytes up with
   // the pattern so every pattern byte is compared at a fixed place
   always_comb begin
      win_in[0] = head.data_byte;
      for (int k = 1; k < WD; k++) begin
         win_in[k] = win_ff[k-1];
      end
      for (int m = 0; m < WD; m++) begin
         win_vec[8*m +: 8] = win_in[WD-1-m];
      end
      win_align = win_vec >> {pad, 3'b000};
      hit = 1'b1;
      for (int j = 0; j < WD; j++) begin
         if (LW'(j) < len &&
             lsm_pkg::fold_char(win_align[8*j +: 8], cfg.case_fold) !=
             lsm_pkg::fold_char(pattern_ff[j], cfg.case_fold)) begin
            hit = 1'b0;
         end
      end
   end

   assign kept_next  = kept_ff + KW'(1);
   assign enough     = CW'(kept_next) >= CW'(len);
   assign start      = KW'(CW'(kept_ff) + CW'(1) - CW'(len));
   assign matched    = hits_ff != 9'd0;
   assign total_next = (matched && total_ff != 16'hFFFF) ? total_ff + 16'd1 : total_ff;

   assign is_end       = head.kind == lsm_pkg::KIND_END;
   assign closing      = is_end || head.kind == lsm_pkg::KIND_NEWLINE;
   assign makes_result = is_end || (head.kind == lsm_pkg::KIND_NEWLINE && matched);
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign pop          = head_valid && (!makes_result || out_free);

   assign text_take = pop && head.kind == lsm_pkg::KIND_TEXT &&
                      !zero_ff && CW'(kept_ff) < CW'(LINE_KEEP);
   assign win_shift = text_take && head.data_byte != lsm_pkg::ZERO_CHAR;
   assign idx9      = {2'b00, head.pattern_index};
   assign first_out = 9'(first_ff);

   always_comb begin
      kept_in       = kept_ff;
      next_start_in = next_start_ff;
      first_in      = first_ff;
      hits_in       = hits_ff;
      zero_in       = zero_ff;
      line_in       = line_ff;
      total_in      = total_ff;
      if (text_take && head.data_byte == lsm_pkg::ZERO_CHAR) begin
         zero_in = 1'b1;
      end
      if (win_shift) begin
         kept_in = kept_next;
         if (enough && hit) begin
            if (hits_ff == 9'd0) begin
               first_in = start;
            end
            if (start >= next_start_ff) begin
               if (hits_ff != 9'd511) begin
                  hits_in = hits_ff + 9'd1;
               end
               next_start_in = kept_next;
            end
         end
      end
      if (pop && closing) begin
         kept_in       = '0;
         next_start_in = '0;
         first_in      = '0;
         hits_in       = '0;
         zero_in       = 1'b0;
         if (is_end) begin
            line_in  = 16'd1;
            total_in = 16'd0;
         end else begin
            total_in = total_next;
            if (line_ff != 16'hFFFF) begin
               line_in = line_ff + 16'd1;
            end
         end
      end
   end

   always_comb begin
      out_in.line_number          = line_ff;
      out_in.line_matched         = matched;
      out_in.first_column         = matched ? first_out : 9'd0;
      out_in.occurrence_count     = matched ? hits_ff : 9'd0;
      out_in.matching_lines_total = total_next;
      out_in.end_of_text          = is_end;
      out_valid_in = out_valid_ff;
      if (pop && makes_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff       <= '0;
         next_start_ff <= '0;
         first_ff      <= '0;
         hits_ff       <= '0;
         zero_ff       <= 1'b0;
         line_ff       <= 16'd1;
         total_ff      <= 16'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         kept_ff       <= kept_in;
         next_start_ff <= next_start_in;
         first_ff      <= first_in;
         hits_ff       <= hits_in;
         zero_ff       <= zero_in;
         line_ff       <= line_in;
         total_ff      <= total_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && makes_result) begin
         out_ff <= out_in;
      end
      if (win_shift) begin
         for (int k = 0; k < WD; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
      if (pop && head.kind == lsm_pkg::KIND_PATTERN && idx9 < 9'(PATTERN_MAX)) begin
         pattern_ff[idx9[LW-1:0]] <= head.data_byte;
      end
   end

   assign rsp_if.valid                = out_valid_ff;
   assign rsp_if.line_number          = out_ff.line_number;
   assign rsp_if.line_matched         = out_ff.line_matched;
   assign rsp_if.first_column         = out_ff.first_column;
   assign rsp_if.occurrence_count     = out_ff.occurrence_count;
   assign rsp_if.matching_lines_total = out_ff.matching_lines_total;
   assign rsp_if.end_of_text          = out_ff.end_of_text;

`ifndef ASSERT_OFF
   a_first_in_line: assert property (@(posedge clock) disable iff (reset)
      hits_ff != 9'd0 |-> first_ff < kept_ff)
      else $error("first match column beyond kept bytes");

   a_next_start_bound: assert property (@(posedge clock) disable iff (reset)
      next_start_ff <= kept_ff)
      else $error("next allowed start beyond kept bytes");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      pop && is_end |=> line_ff == 16'd1 && total_ff == 16'd0 && out_valid_ff)
      else $error("end of text did not restart counters or post result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_if.ready |=> $stable(out_ff))
      else $error("pending result overwritten");
`endif

endmodule

>>> hw/rtl/line_substring_matcher.sv
// line_substring_matcher: top level of the line oriented substring matcher
// depends on lsm_pkg, lsm_channels, lsm_front, lsm_queue and lsm_back
//
// usage
//  - csr_if writes case_fold (index 0) and pattern_length (index 1); it is
//    always ready and the new value applies from the next text beat
//  - req_if beats carry an action: load one pattern byte at pattern_index,
//    one text byte, or end of text
//  - text bytes are split into lines at newline; a matching line produces
//    one rsp_if beat, end of text always produces one final beat
// timing
//  - one request beat per cycle while the queue has space; a result shows on
//    rsp_if once its request beat has passed a queue slot and then the result
//    register, and is held there until it is taken
//  - the back end compares the whole pattern window against the newest bytes
//    combinationally, so text runs at one byte per clock when no result stalls
// reset and stall
//  - reset clears line state and counters, case_fold to 0, pattern_length to 1;
//    pattern bytes are undefined until loaded
//  - a stalled rsp_if holds its beat; the back end keeps consuming beats that
//    produce no result, and req_if drops ready only once the queue is full

module line_substring_matcher #(
   parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF,
   parameter int LINE_KEEP   = lsm_pkg::LINE_KEEP_DEF
) (
   input logic        clock,
   input logic        reset,
   lsm_req_if.sink    req_if,
   lsm_rsp_if.source  rsp_if,
   lsm_csr_if.sink    csr_if
);

   lsm_pkg::cfg_type   cfg_ff, cfg_in;
   lsm_pkg::entry_type push_entry, head;
   logic               queue_space, push, head_valid, pop;

   // configuration registers, always ready
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            lsm_pkg::CSR_CASE_FOLD: begin
               cfg_in.case_fold = csr_if.data[0];
            end
            lsm_pkg::CSR_PATTERN_LEN: begin
               cfg_in.pattern_length = csr_if.data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.case_fold      <= 1'b0;
         cfg_ff.pattern_length <= 7'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: classify and enqueue
   lsm_front u_front (
      .req_if      (req_if),
      .queue_space (queue_space),
      .push        (push),
      .push_entry  (push_entry)
   );

   lsm_queue #(
      .DEPTH (lsm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .has_space  (queue_space),
      .pop        (pop),
      .not_empty  (head_valid),
      .head       (head)
   );

   // back end: matching and result register
   lsm_back #(
      .PATTERN_MAX (PATTERN_MAX),
      .LINE_KEEP   (LINE_KEEP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule
